// ===== design/arfv_pkg.sv =====
// Shared types and constants for the vector alignment rotation unit.
// No dependencies.
package arfv_pkg;

   localparam int FRAC     = 30;        // fraction bits of unit vectors and results
   localparam int NORM_MSB = 29;        // normalized magnitude lies in [2^29, 2^30)
   localparam int SQ_STEPS = 32;        // square root steps for a 62-bit radicand
   localparam int UQB      = 31;        // quotient bits of a unit component
   localparam int TQB      = 34;        // quotient bits of a quadratic term

   localparam logic [31:0] ONE_Q = 32'd1 << FRAC;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_PARALLEL = 2'd1;
   localparam status_type ST_ANTI     = 2'd2;
   localparam status_type ST_ZERO     = 2'd3;

   // one direction on its way through normalization and square root
   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][29:0] u;
   } unit_side_type;

   typedef struct packed {
      logic       zero;
      logic [2:0] neg;
   } unit_tag_type;

   // side data riding along with the quadratic term dividers
   typedef struct packed {
      logic             zero;
      logic             s2zero;
      logic [5:0]       neg;
      logic [32:0]      c;
      logic [2:0][32:0] v;
   } term_tag_type;

   typedef struct packed {
      logic [8:0][31:0] e;
      status_type       status;
   } rsp_data_type;

endpackage

// ===== design/arfv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; instantiated by align_rotation_from_vectors_unit.
module arfv_div #(
   parameter int NUM_W = 61,
   parameter int DEN_W = 31,
   parameter int QB    = 31
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QB-1:0]    quo
);

   // num >> QB must be below den
   logic [DEN_W-1:0] rem_ff [0:QB-1];
   logic [QB-1:0]    low_ff [0:QB-1];
   logic [DEN_W-1:0] den_ff [0:QB-1];
   logic [QB-1:0]    q_ff   [0:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num[NUM_W-1:QB]);
         low_ff[0] <= num[QB-1:0];
         den_ff[0] <= den;
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           fits;
      assign trial = {rem_ff[k], low_ff[k][QB-1-k]};
      assign fits  = trial >= {1'b0, den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k+1] <= {q_ff[k][QB-2:0], fits};
         end
      end
      if (k < QB - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= fits ? DEN_W'(trial - {1'b0, den_ff[k]}) : DEN_W'(trial);
               low_ff[k+1] <= low_ff[k];
               den_ff[k+1] <= den_ff[k];
            end
         end
      end
   end

   assign quo = q_ff[QB];

endmodule

// ===== design/align_rotation_from_vectors_unit.sv =====
// Rotation matrix aligning two viewing directions, Rodrigues form, fully pipelined.
// Depends on arfv_pkg and arfv_div.
//
// Takes two object positions and a camera position (signed Q16.16), forms the
// unit directions a and b from the camera to each object, and returns the
// rotation R = I + [v]x + [v]x^2 (1 - c) / |v|^2 with v = a x b, c = a . b as
// nine signed fixed-point entries (OUT_WIDTH-2 fraction bits, saturated,
// sign-extended to 32 bits). Status: 0 ok, 1 parallel (identity), 2
// antiparallel (entries zero), 3 zero-length direction (entries zero).
// One request is accepted every cycle while req_stall is low, and each request
// returns one response. The pipeline depth is set mostly by the 32-step square
// root of each direction length and by the two long division pipelines (31
// bits for the unit components, 34 bits for the quadratic terms), each
// retiring one bit per stage. A two-entry output buffer (output register plus
// skid) lets the pipe keep taking requests while a finished response waits;
// req_stall rises only when both entries hold data.
module align_rotation_from_vectors_unit
   import arfv_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int OUT_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   input  logic signed [31:0] req_cam_x,
   input  logic signed [31:0] req_cam_y,
   input  logic signed [31:0] req_cam_z,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_r_row0,
   output logic signed [31:0] rsp_r_row0_col2,
   output logic [63:0]        rsp_r_row1,
   output logic signed [31:0] rsp_r_row1_col2,
   output logic [63:0]        rsp_r_row2,
   output logic signed [31:0] rsp_r_row2_col2,
   output logic [1:0]         rsp_status
);

   localparam int IN_W  = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int SH    = 32 - OUT_WIDTH;     // rounding shift on the way out
   localparam int UDIV  = UQB + 1;            // unit divider latency
   localparam int TDIV  = TQB + 1;            // term divider latency
   // A, B, C, D, E + sqrt + unit div + 3 product stages + 4 term prep + term div + 2 final
   localparam int LAT   = 5 + SQ_STEPS + UDIV + 3 + 4 + TDIV + 2;

   localparam logic signed [38:0] E_HI = (39'sd1 <<< (OUT_WIDTH - 1)) - 39'sd1;
   localparam logic signed [38:0] E_LO = -E_HI - 39'sd1;

   // ---------------------------------------------------------------- helpers

   function automatic logic signed [32:0] sext_coord(input logic [31:0] x);
      return 33'($signed(x[IN_W-1:0]));
   endfunction

   // round half away from zero, drop FRAC bits
   function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x);
      logic [63:0] mag;
      mag = x[63] ? 64'(-x) : 64'(x);
      mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
      return x[63] ? -$signed(mag) : $signed(mag);
   endfunction

   // round to OUT_WIDTH-2 fraction bits, saturate, sign-extend to 32
   function automatic logic [31:0] emit_entry(input logic signed [37:0] x);
      logic [37:0]        mag;
      logic signed [38:0] val;
      mag = x[37] ? 38'(-x) : 38'(x);
      mag = (mag + ((38'd1 << SH) >> 1)) >> SH;
      val = x[37] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      if (val > E_HI) val = E_HI;
      if (val < E_LO) val = E_LO;
      return 32'(val);
   endfunction

   // ---------------------------------------------------------- flow control

   logic               adv;           // whole pipe moves one stage
   logic [LAT-1:0]     vld_ff;
   rsp_data_type       pipe_data;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;
   logic               skid_valid_ff;
   rsp_data_type       skid_data_ff;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ------------------------------------------- stage A: camera differences

   logic [31:0]        obj_raw [0:1][0:2];
   logic [31:0]        cam_raw [0:2];
   logic signed [32:0] a_diff  [0:1][0:2];
   logic               a_neg_in [0:1][0:2];
   logic [31:0]        a_mag_in [0:1][0:2];
   logic               a_neg_ff [0:1][0:2];
   logic [31:0]        a_mag_ff [0:1][0:2];

   assign obj_raw[0][0] = req_first_x;
   assign obj_raw[0][1] = req_first_y;
   assign obj_raw[0][2] = req_first_z;
   assign obj_raw[1][0] = req_second_x;
   assign obj_raw[1][1] = req_second_y;
   assign obj_raw[1][2] = req_second_z;
   assign cam_raw[0]    = req_cam_x;
   assign cam_raw[1]    = req_cam_y;
   assign cam_raw[2]    = req_cam_z;

   always_comb begin
      for (int d = 0; d < 2; d++) begin
         for (int i = 0; i < 3; i++) begin
            a_diff[d][i]   = sext_coord(obj_raw[d][i]) - sext_coord(cam_raw[i]);
            a_neg_in[d][i] = a_diff[d][i][32];
            a_mag_in[d][i] = a_diff[d][i][32] ? 32'(-a_diff[d][i]) : 32'(a_diff[d][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_neg_ff <= a_neg_in;
         a_mag_ff <= a_mag_in;
      end
   end

   // --------------------------------------- stage B: leading one of the max

   logic [31:0] b_or     [0:1];
   logic [4:0]  b_pos_in [0:1];
   logic [4:0]  b_pos_ff [0:1];
   logic        b_zero_ff [0:1];
   logic        b_neg_ff [0:1][0:2];
   logic [31:0] b_mag_ff [0:1][0:2];

   always_comb begin
      for (int d = 0; d < 2; d++) begin
         b_or[d]     = a_mag_ff[d][0] | a_mag_ff[d][1] | a_mag_ff[d][2];
         b_pos_in[d] = '0;
         for (int k = 0; k < 32; k++) begin
            if (b_or[d][k]) b_pos_in[d] = 5'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_pos_ff <= b_pos_in;
         b_neg_ff <= a_neg_ff;
         b_mag_ff <= a_mag_ff;
         for (int d = 0; d < 2; d++) begin
            b_zero_ff[d] <= (b_or[d] == '0);
         end
      end
   end

   // -------------------------- stage C: common shift to put max in [2^29, 2^30)

   unit_side_type c_side_in [0:1];
   unit_side_type c_side_ff [0:1];

   always_comb begin
      for (int d = 0; d < 2; d++) begin
         c_side_in[d].zero = b_zero_ff[d];
         for (int i = 0; i < 3; i++) begin
            c_side_in[d].neg[i] = b_neg_ff[d][i];
            if (b_pos_ff[d] >= 5'(NORM_MSB)) begin
               c_side_in[d].u[i] = 30'(b_mag_ff[d][i] >> (b_pos_ff[d] - 5'(NORM_MSB)));
            end else begin
               c_side_in[d].u[i] = 30'(b_mag_ff[d][i] << (5'(NORM_MSB) - b_pos_ff[d]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) c_side_ff <= c_side_in;
   end

   // ------------------------------------------------------ stage D: squares

   unit_side_type d_side_ff [0:1];
   logic [59:0]   d_sq_ff   [0:1][0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= c_side_ff;
         for (int d = 0; d < 2; d++) begin
            for (int i = 0; i < 3; i++) begin
               d_sq_ff[d][i] <= 60'(c_side_ff[d].u[i]) * 60'(c_side_ff[d].u[i]);
            end
         end
      end
   end

   // ------------------- stage E and square root: one result bit per stage

   logic [61:0]   sq_n_ff    [0:1][0:SQ_STEPS-1];
   logic [62:0]   sq_r_ff    [0:1][0:SQ_STEPS];
   unit_side_type sq_side_ff [0:1][0:SQ_STEPS];

   for (genvar g = 0; g < 2; g++) begin : g_dir
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_n_ff[g][0]    <= 62'(d_sq_ff[g][0]) + 62'(d_sq_ff[g][1]) + 62'(d_sq_ff[g][2]);
            sq_r_ff[g][0]    <= '0;
            sq_side_ff[g][0] <= d_side_ff[g];
         end
      end

      for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
         localparam logic [62:0] BIT = 63'd1 << (62 - 2 * k);
         logic [62:0] trial;
         logic        fits;
         assign trial = sq_r_ff[g][k] + BIT;
         assign fits  = {1'b0, sq_n_ff[g][k]} >= trial;
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_r_ff[g][k+1]    <= fits ? (sq_r_ff[g][k] >> 1) + BIT : sq_r_ff[g][k] >> 1;
               sq_side_ff[g][k+1] <= sq_side_ff[g][k];
            end
         end
         if (k < SQ_STEPS - 1) begin : g_rem
            always_ff @(posedge clock) begin
               if (adv) begin
                  sq_n_ff[g][k+1] <= fits ? 62'({1'b0, sq_n_ff[g][k]} - trial)
                                          : sq_n_ff[g][k];
               end
            end
         end
      end
   end

   // ------------------ unit components: round(u * 2^30 / len), one per divider

   logic [30:0]        ulen   [0:1];
   logic [60:0]        unum   [0:1][0:2];
   logic [UQB-1:0]     uquo   [0:1][0:2];
   unit_tag_type       ut_ff  [0:1][0:UDIV-1];
   logic signed [31:0] av     [0:1][0:2];

   for (genvar g = 0; g < 2; g++) begin : g_unit
      assign ulen[g] = sq_r_ff[g][SQ_STEPS][30:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            ut_ff[g][0].zero <= sq_side_ff[g][SQ_STEPS].zero;
            ut_ff[g][0].neg  <= sq_side_ff[g][SQ_STEPS].neg;
            for (int s = 1; s < UDIV; s++) ut_ff[g][s] <= ut_ff[g][s-1];
         end
      end

      for (genvar i = 0; i < 3; i++) begin : g_comp
         assign unum[g][i] = (61'(sq_side_ff[g][SQ_STEPS].u[i]) << FRAC) + 61'(ulen[g] >> 1);

         arfv_div #(
            .NUM_W(61),
            .DEN_W(31),
            .QB   (UQB)
         ) u_udiv (
            .clock(clock),
            .en   (adv),
            .num  (unum[g][i]),
            .den  (ulen[g]),
            .quo  (uquo[g][i])
         );

         assign av[g][i] = ut_ff[g][UDIV-1].neg[i] ? -$signed({1'b0, uquo[g][i]})
                                                   :  $signed({1'b0, uquo[g][i]});
      end
   end

   // ------------------------------- M1..M3: cross and dot products, rounded

   logic signed [63:0] m1_p_ff [0:2][0:2];
   logic               m1_zero_ff;
   logic signed [63:0] m2_x_ff [0:2];
   logic signed [63:0] m2_dot_ff;
   logic               m2_zero_ff;
   logic signed [32:0] m3_v_ff [0:2];
   logic signed [32:0] m3_c_ff;
   logic               m3_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               m1_p_ff[i][j] <= 64'(av[0][i]) * 64'(av[1][j]);
            end
         end
         m1_zero_ff <= ut_ff[0][UDIV-1].zero | ut_ff[1][UDIV-1].zero;

         m2_x_ff[0] <= m1_p_ff[1][2] - m1_p_ff[2][1];
         m2_x_ff[1] <= m1_p_ff[2][0] - m1_p_ff[0][2];
         m2_x_ff[2] <= m1_p_ff[0][1] - m1_p_ff[1][0];
         m2_dot_ff  <= m1_p_ff[0][0] + m1_p_ff[1][1] + m1_p_ff[2][2];
         m2_zero_ff <= m1_zero_ff;

         for (int i = 0; i < 3; i++) m3_v_ff[i] <= 33'(rnd_frac(m2_x_ff[i]));
         m3_c_ff    <= 33'(rnd_frac(m2_dot_ff));
         m3_zero_ff <= m2_zero_ff;
      end
   end

   // --------------------- V1..V4: [v]x^2 entries, (1-c) scaling, dividends
   // term order: (0,0) (1,1) (2,2) (0,1) (0,2) (1,2)

   logic signed [63:0] v1_p_ff [0:5];
   logic signed [33:0] v1_omc_ff;
   logic signed [32:0] v1_v_ff [0:2];
   logic signed [32:0] v1_c_ff;
   logic               v1_zero_ff;

   logic signed [63:0] v2_sq [0:5];
   logic [61:0]        v2_s2_ff;
   logic [61:0]        v2_ms_ff [0:5];
   logic [5:0]         v2_neg_ff;
   logic [32:0]        v2_mo_ff;
   logic signed [32:0] v2_v_ff [0:2];
   logic signed [32:0] v2_c_ff;
   logic               v2_zero_ff;

   logic [63:0]        v3_lo_ff [0:5];
   logic [63:0]        v3_hi_ff [0:5];
   logic [61:0]        v3_s2_ff;
   logic               v3_s2zero_ff;
   logic [5:0]         v3_neg_ff;
   logic signed [32:0] v3_v_ff [0:2];
   logic signed [32:0] v3_c_ff;
   logic               v3_zero_ff;

   logic [94:0]        v4_num_ff [0:5];
   logic [61:0]        v4_s2_ff;
   term_tag_type       v4_tag_ff;

   always_comb begin
      v2_sq[0] = -(v1_p_ff[1] + v1_p_ff[2]);
      v2_sq[1] = -(v1_p_ff[0] + v1_p_ff[2]);
      v2_sq[2] = -(v1_p_ff[0] + v1_p_ff[1]);
      v2_sq[3] = v1_p_ff[3];
      v2_sq[4] = v1_p_ff[4];
      v2_sq[5] = v1_p_ff[5];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v1_p_ff[0] <= 64'(m3_v_ff[0]) * 64'(m3_v_ff[0]);
         v1_p_ff[1] <= 64'(m3_v_ff[1]) * 64'(m3_v_ff[1]);
         v1_p_ff[2] <= 64'(m3_v_ff[2]) * 64'(m3_v_ff[2]);
         v1_p_ff[3] <= 64'(m3_v_ff[0]) * 64'(m3_v_ff[1]);
         v1_p_ff[4] <= 64'(m3_v_ff[0]) * 64'(m3_v_ff[2]);
         v1_p_ff[5] <= 64'(m3_v_ff[1]) * 64'(m3_v_ff[2]);
         v1_omc_ff  <= $signed({2'b00, ONE_Q}) - 34'(m3_c_ff);
         v1_v_ff    <= m3_v_ff;
         v1_c_ff    <= m3_c_ff;
         v1_zero_ff <= m3_zero_ff;

         v2_s2_ff <= 62'(v1_p_ff[0] + v1_p_ff[1] + v1_p_ff[2]);
         for (int k = 0; k < 6; k++) begin
            v2_ms_ff[k]  <= v2_sq[k][63] ? 62'(-v2_sq[k]) : 62'(v2_sq[k]);
            v2_neg_ff[k] <= v1_omc_ff[33] ^ v2_sq[k][63];
         end
         v2_mo_ff   <= v1_omc_ff[33] ? 33'(-v1_omc_ff) : 33'(v1_omc_ff);
         v2_v_ff    <= v1_v_ff;
         v2_c_ff    <= v1_c_ff;
         v2_zero_ff <= v1_zero_ff;

         // 33 x 62 product in two halves
         for (int k = 0; k < 6; k++) begin
            v3_lo_ff[k] <= 64'(v2_mo_ff) * 64'(v2_ms_ff[k][30:0]);
            v3_hi_ff[k] <= 64'(v2_mo_ff) * 64'(v2_ms_ff[k][61:31]);
         end
         v3_s2_ff     <= v2_s2_ff;
         v3_s2zero_ff <= (v2_s2_ff == '0);
         v3_neg_ff    <= v2_neg_ff;
         v3_v_ff      <= v2_v_ff;
         v3_c_ff      <= v2_c_ff;
         v3_zero_ff   <= v2_zero_ff;

         for (int k = 0; k < 6; k++) begin
            v4_num_ff[k] <= 95'(v3_lo_ff[k]) + (95'(v3_hi_ff[k]) << 31) + 95'(v3_s2_ff >> 1);
         end
         v4_s2_ff         <= v3_s2_ff;
         v4_tag_ff.zero   <= v3_zero_ff;
         v4_tag_ff.s2zero <= v3_s2zero_ff;
         v4_tag_ff.neg    <= v3_neg_ff;
         v4_tag_ff.c      <= v3_c_ff;
         for (int i = 0; i < 3; i++) v4_tag_ff.v[i] <= v3_v_ff[i];
      end
   end

   // ------------------------------------------------ quadratic term dividers

   logic [TQB-1:0] tquo [0:5];
   term_tag_type   tt_ff [0:TDIV-1];

   for (genvar k = 0; k < 6; k++) begin : g_term
      arfv_div #(
         .NUM_W(95),
         .DEN_W(62),
         .QB   (TQB)
      ) u_tdiv (
         .clock(clock),
         .en   (adv),
         .num  (v4_num_ff[k]),
         .den  (v4_s2_ff),
         .quo  (tquo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tt_ff[0] <= v4_tag_ff;
         for (int s = 1; s < TDIV; s++) tt_ff[s] <= tt_ff[s-1];
      end
   end

   // --------------------------- F1: assemble entries and pick special cases

   term_tag_type       f_tag;
   logic signed [35:0] f_t  [0:5];
   logic signed [37:0] f_v  [0:2];
   logic signed [37:0] f_e_in [0:8];
   status_type         f_status_in;
   logic signed [37:0] f1_e_ff [0:8];
   status_type         f1_status_ff;

   always_comb begin
      f_tag = tt_ff[TDIV-1];
      for (int k = 0; k < 6; k++) begin
         f_t[k] = f_tag.neg[k] ? -$signed({2'b00, tquo[k]}) : $signed({2'b00, tquo[k]});
      end
      for (int i = 0; i < 3; i++) f_v[i] = 38'($signed(f_tag.v[i]));

      f_e_in[0] = $signed({6'd0, ONE_Q}) + 38'(f_t[0]);
      f_e_in[1] = -f_v[2] + 38'(f_t[3]);
      f_e_in[2] =  f_v[1] + 38'(f_t[4]);
      f_e_in[3] =  f_v[2] + 38'(f_t[3]);
      f_e_in[4] = $signed({6'd0, ONE_Q}) + 38'(f_t[1]);
      f_e_in[5] = -f_v[0] + 38'(f_t[5]);
      f_e_in[6] = -f_v[1] + 38'(f_t[4]);
      f_e_in[7] =  f_v[0] + 38'(f_t[5]);
      f_e_in[8] = $signed({6'd0, ONE_Q}) + 38'(f_t[2]);

      if (f_tag.zero) begin
         f_status_in = ST_ZERO;
      end else if (f_tag.s2zero) begin
         f_status_in = ($signed(f_tag.c) > 0) ? ST_PARALLEL : ST_ANTI;
      end else begin
         f_status_in = ST_OK;
      end

      case (f_status_in)
         ST_OK: begin
         end
         ST_PARALLEL: begin
            for (int k = 0; k < 9; k++) begin
               f_e_in[k] = (k % 4 == 0) ? $signed({6'd0, ONE_Q}) : '0;
            end
         end
         default: begin
            for (int k = 0; k < 9; k++) f_e_in[k] = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_e_ff      <= f_e_in;
         f1_status_ff <= f_status_in;
      end
   end

   // ------------------------------------------- F2: round and saturate

   rsp_data_type f2_data_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) f2_data_ff.e[k] <= emit_entry(f1_e_ff[k]);
         f2_data_ff.status <= f1_status_ff;
      end
   end

   assign pipe_data = f2_data_ff;

   // --------------------------------------- output register and skid entry

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         if (vld_ff[LAT-1]) begin
            if (out_free) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (vld_ff[LAT-1]) begin
            if (out_free) rsp_data_ff <= pipe_data;
            else          skid_data_ff <= pipe_data;
         end
      end else if (out_free) begin
         rsp_data_ff <= skid_data_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_r_row0      = {rsp_data_ff.e[0], rsp_data_ff.e[1]};
   assign rsp_r_row0_col2 = $signed(rsp_data_ff.e[2]);
   assign rsp_r_row1      = {rsp_data_ff.e[3], rsp_data_ff.e[4]};
   assign rsp_r_row1_col2 = $signed(rsp_data_ff.e[5]);
   assign rsp_r_row2      = {rsp_data_ff.e[6], rsp_data_ff.e[7]};
   assign rsp_r_row2_col2 = $signed(rsp_data_ff.e[8]);
   assign rsp_status      = rsp_data_ff.status;

   // ------------------------------------------------------------ assertions

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds data while output register is empty");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(vld_ff))
      else $error("pipe moved while skid entry was full");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter the pipe");

   a_zero_dir_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO) |->
         (rsp_r_row0 == '0 && rsp_r_row1 == '0 && rsp_r_row2 == '0 &&
          rsp_r_row0_col2 == '0 && rsp_r_row1_col2 == '0 && rsp_r_row2_col2 == '0))
      else $error("zero-length direction response carries nonzero entries");

endmodule
